@@ hdl/obsc_pkg.sv @@
// Shared constants, types and register codes for the oriented box clip unit.
`timescale 1ns / 1ps
`default_nettype none
package obsc_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int PARAM_FRAC_BITS = 30;
  localparam int PACK_WIDTH      = 21;
  localparam int REG_WIDTH       = 3 * PACK_WIDTH;
  localparam int THR_WIDTH       = 31;
  localparam int TOL_FRAC        = 20;
  localparam int TOL_SHIFT       = PARAM_FRAC_BITS - TOL_FRAC;
  localparam int CFG_IDX_WIDTH   = 3;

  localparam int U_WIDTH   = 63;
  localparam int NUM_WIDTH = 64;
  localparam int MAG_WIDTH = 63;
  localparam int T_WIDTH   = 32;

  localparam logic [63:0] U_LIM = 64'd1 << 61;

  localparam logic signed [NUM_WIDTH-1:0] N_ONE = NUM_WIDTH'(64'd1 << PARAM_FRAC_BITS);
  localparam logic signed [T_WIDTH-1:0]   T_ONE = T_WIDTH'(64'd1 << PARAM_FRAC_BITS);
  localparam logic [T_WIDTH-1:0] T_BOUND_POS = {1'b0, {(T_WIDTH-1){1'b1}}};
  localparam logic [T_WIDTH-1:0] T_BOUND_NEG = {1'b1, {(T_WIDTH-1){1'b0}}};

  localparam int NORM_LAT = 7;
  localparam int DIV_LAT  = T_WIDTH + 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CORNER    = 3'd0,
    REG_EDGE_LEN  = 3'd1,
    REG_EDGE_WID  = 3'd2,
    REG_EDGE_HGT  = 3'd3,
    REG_INV_SQ    = 3'd4,
    REG_AXIS_TOL  = 3'd5,
    REG_PAR_THR   = 3'd6,
    REG_SEG_TOL   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       kind;
    logic       point_rel;
    logic       reject;
    logic [2:0] use_axis;
  } clip_flags_t;

endpackage
`default_nettype wire

@@ hdl/obsc_delay.sv @@
// Resettable delay line for valid bits and request flags.
`timescale 1ns / 1ps
`default_nettype none
module obsc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule
`default_nettype wire

@@ hdl/obsc_norm.sv @@
// Pipelined normalised box coordinate along one axis: dot product, scale, saturate.
`timescale 1ns / 1ps
`default_nettype none
module obsc_norm import obsc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int DIFF_W =
    (((COORD_WIDTH + 1) > PACK_WIDTH) ? (COORD_WIDTH + 1) : PACK_WIDTH) + 1
) (
  input  wire logic                                clk,
  input  wire logic signed [DIFF_W-1:0]            diff [3],
  input  wire logic        [REG_WIDTH-1:0]         edge_vec,
  input  wire logic        [PACK_WIDTH-1:0]        inv,
  output logic signed      [U_WIDTH-1:0]           u
);

  localparam int PROD_W = DIFF_W + PACK_WIDTH;
  localparam int DOT_W  = PROD_W + 2;
  localparam int HALF   = (DOT_W + 1) / 2;
  localparam int HI_W   = DOT_W - HALF;
  localparam int PLO_W  = HALF + PACK_WIDTH;
  localparam int PHI_W  = HI_W + PACK_WIDTH;
  localparam int P_W    = DOT_W + PACK_WIDTH;
  localparam int R_W    = U_WIDTH - 1;
  localparam int SH     = 2 * COORD_WIDTH - PARAM_FRAC_BITS;
  localparam int SHA    = (SH >= 0) ? SH : -SH;

  logic signed [PROD_W-1:0] prod [3];
  logic signed [DOT_W-1:0]  dot;
  logic        [DOT_W-1:0]  mag;
  logic                     neg_c, neg_d, neg_e, neg_f;
  logic        [PLO_W-1:0]  plo;
  logic        [PHI_W-1:0]  phi;
  logic        [P_W-1:0]    prd;
  logic        [R_W-1:0]    r;
  logic        [R_W-1:0]    r_next;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= diff[i] * $signed(edge_vec[i*PACK_WIDTH +: PACK_WIDTH]);
    end
    dot   <= DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
    neg_c <= dot[DOT_W-1];
    mag   <= dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    neg_d <= neg_c;
    plo   <= PLO_W'(mag[HALF-1:0]) * PLO_W'(inv);
    phi   <= PHI_W'(mag[DOT_W-1:HALF]) * PHI_W'(inv);
    neg_e <= neg_d;
    prd   <= (P_W'(phi) << HALF) + P_W'(plo);
    neg_f <= neg_e;
    r     <= r_next;
    u     <= neg_f ? -$signed(U_WIDTH'(r)) : $signed(U_WIDTH'(r));
  end

  generate
    if (SH >= 0) begin : g_rsh
      logic [P_W-1:0] shd;
      assign shd    = prd >> SHA;
      assign r_next = (shd > P_W'(U_LIM)) ? R_W'(U_LIM) : R_W'(shd);
    end else begin : g_lsh
      assign r_next = (prd > P_W'(U_LIM >> SHA)) ? R_W'(U_LIM) : R_W'(prd << SHA);
    end
  endgenerate

endmodule
`default_nettype wire

@@ hdl/obsc_div.sv @@
// Pipelined restoring divider for slab parameters, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module obsc_div import obsc_pkg::*; (
  input  wire logic                        clk,
  input  wire logic signed [NUM_WIDTH-1:0] num,
  input  wire logic signed [NUM_WIDTH-1:0] den,
  output logic signed      [T_WIDTH-1:0]   quo
);

  localparam int SHQ = T_WIDTH - PARAM_FRAC_BITS;

  logic [MAG_WIDTH-1:0] nm, dm;
  logic                 ng0;
  logic [MAG_WIDTH-1:0] rem [T_WIDTH+1];
  logic [T_WIDTH-1:0]   qs  [T_WIDTH+1];
  logic [MAG_WIDTH-1:0] dv  [T_WIDTH+1];
  logic                 ng  [T_WIDTH+1];
  logic                 sat [T_WIDTH+1];
  logic [T_WIDTH-1:0]   bound, qmag;

  always_ff @(posedge clk) begin
    nm  <= num[NUM_WIDTH-1] ? MAG_WIDTH'(-num) : MAG_WIDTH'(num);
    dm  <= den[NUM_WIDTH-1] ? MAG_WIDTH'(-den) : MAG_WIDTH'(den);
    ng0 <= num[NUM_WIDTH-1] ^ den[NUM_WIDTH-1];
    rem[0] <= MAG_WIDTH'(nm[MAG_WIDTH-1:SHQ]);
    qs[0]  <= {nm[SHQ-1:0], {PARAM_FRAC_BITS{1'b0}}};
    dv[0]  <= dm;
    ng[0]  <= ng0;
    sat[0] <= {{SHQ{1'b0}}, nm} >= {dm, {SHQ{1'b0}}};
  end

  genvar k;
  generate
    for (k = 0; k < T_WIDTH; k++) begin : g_step
      logic [MAG_WIDTH:0] trial;
      logic               ge;
      assign trial = {rem[k], qs[k][T_WIDTH-1]};
      assign ge    = trial >= {1'b0, dv[k]};
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? MAG_WIDTH'(trial - {1'b0, dv[k]}) : trial[MAG_WIDTH-1:0];
        qs[k+1]  <= {qs[k][T_WIDTH-2:0], ge};
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        sat[k+1] <= sat[k];
      end
    end
  endgenerate

  always_comb begin
    bound = ng[T_WIDTH] ? T_BOUND_NEG : T_BOUND_POS;
    qmag  = (sat[T_WIDTH] || (qs[T_WIDTH] > bound)) ? bound : qs[T_WIDTH];
  end

  always_ff @(posedge clk) begin
    quo <= ng[T_WIDTH] ? -$signed(qmag) : $signed(qmag);
  end

endmodule
`default_nettype wire

@@ hdl/oriented_box_segment_clip.sv @@
// Top level: oriented box point containment and slab-method segment clip.
// Throughput: one request per cycle; busy is always low.
// The 32-stage divider, one quotient bit per stage, sets most of the latency.
// Results cannot be held off; done marks each one for a single cycle.
// Reset (rst, synchronous) clears all configuration registers and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module oriented_box_segment_clip import obsc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] start_y,
  input  wire logic signed [COORD_WIDTH-1:0] start_z,
  input  wire logic signed [COORD_WIDTH-1:0] delta_x,
  input  wire logic signed [COORD_WIDTH-1:0] delta_y,
  input  wire logic signed [COORD_WIDTH-1:0] delta_z,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  wire logic [REG_WIDTH-1:0]          cfg_data,
  output logic                               done,
  output logic                               relation,
  output logic signed [T_WIDTH-1:0]          t_enter,
  output logic signed [T_WIDTH-1:0]          t_exit
);

  localparam int QW     = COORD_WIDTH + 1;
  localparam int DIFF_W = ((QW > PACK_WIDTH) ? QW : PACK_WIDTH) + 1;

  logic [REG_WIDTH-1:0] corner_point, edge_length_vector, edge_width_vector;
  logic [REG_WIDTH-1:0] edge_height_vector, inverse_square_lengths, axis_tolerances;
  logic [THR_WIDTH-1:0] parallel_threshold, segment_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_point           <= '0;
      edge_length_vector     <= '0;
      edge_width_vector      <= '0;
      edge_height_vector     <= '0;
      inverse_square_lengths <= '0;
      axis_tolerances        <= '0;
      parallel_threshold     <= '0;
      segment_tolerance      <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CORNER:   corner_point           <= cfg_data;
        REG_EDGE_LEN: edge_length_vector     <= cfg_data;
        REG_EDGE_WID: edge_width_vector      <= cfg_data;
        REG_EDGE_HGT: edge_height_vector     <= cfg_data;
        REG_INV_SQ:   inverse_square_lengths <= cfg_data;
        REG_AXIS_TOL: axis_tolerances        <= cfg_data;
        REG_PAR_THR:  parallel_threshold     <= cfg_data[THR_WIDTH-1:0];
        REG_SEG_TOL:  segment_tolerance      <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: request register, end point
  logic                   v0, kind0;
  logic signed [QW-1:0]   p0 [3];
  logic signed [QW-1:0]   q0 [3];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
    kind0 <= kind;
    p0[0] <= QW'(start_x);
    p0[1] <= QW'(start_y);
    p0[2] <= QW'(start_z);
    q0[0] <= QW'(start_x) + QW'(delta_x);
    q0[1] <= QW'(start_y) + QW'(delta_y);
    q0[2] <= QW'(start_z) + QW'(delta_z);
  end

  // stage 1: offsets from the corner
  logic                     v1, kind1;
  logic signed [DIFF_W-1:0] dp1 [3];
  logic signed [DIFF_W-1:0] dq1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    kind1 <= kind0;
    for (int i = 0; i < 3; i++) begin
      dp1[i] <= DIFF_W'(p0[i]) - DIFF_W'($signed(corner_point[i*PACK_WIDTH +: PACK_WIDTH]));
      dq1[i] <= DIFF_W'(q0[i]) - DIFF_W'($signed(corner_point[i*PACK_WIDTH +: PACK_WIDTH]));
    end
  end

  logic [REG_WIDTH-1:0]      edge_sel [3];
  logic signed [U_WIDTH-1:0] u1 [3];
  logic signed [U_WIDTH-1:0] u2 [3];

  assign edge_sel[0] = edge_length_vector;
  assign edge_sel[1] = edge_width_vector;
  assign edge_sel[2] = edge_height_vector;

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      obsc_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm_p (
        .clk      (clk),
        .diff     (dp1),
        .edge_vec (edge_sel[a]),
        .inv      (inverse_square_lengths[a*PACK_WIDTH +: PACK_WIDTH]),
        .u        (u1[a])
      );
      obsc_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm_q (
        .clk      (clk),
        .diff     (dq1),
        .edge_vec (edge_sel[a]),
        .inv      (inverse_square_lengths[a*PACK_WIDTH +: PACK_WIDTH]),
        .u        (u2[a])
      );
    end
  endgenerate

  logic [1:0] vk_n;

  obsc_delay #(.WIDTH(2), .DEPTH(NORM_LAT)) u_norm_dly (
    .clk  (clk),
    .rst  (rst),
    .din  ({v1, kind1}),
    .dout (vk_n)
  );

  // stage 7: slab numerators, direction and tolerance checks
  logic                        v7, kind7;
  logic signed [NUM_WIDTH-1:0] e7   [3];
  logic signed [NUM_WIDTH-1:0] nlo7 [3];
  logic signed [NUM_WIDTH-1:0] nhi7 [3];
  logic [2:0]                  out7;
  logic signed [NUM_WIDTH-1:0] tolv [3];
  logic signed [NUM_WIDTH-1:0] thr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tolv[i] = $signed(NUM_WIDTH'(axis_tolerances[i*PACK_WIDTH +: PACK_WIDTH]) << TOL_SHIFT);
    end
    thr = $signed(NUM_WIDTH'(parallel_threshold));
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= vk_n[1];
    kind7 <= vk_n[0];
    for (int i = 0; i < 3; i++) begin
      e7[i]   <= NUM_WIDTH'(u2[i]) - NUM_WIDTH'(u1[i]);
      nlo7[i] <= -NUM_WIDTH'(u1[i]);
      nhi7[i] <= N_ONE - NUM_WIDTH'(u1[i]);
      out7[i] <= (NUM_WIDTH'(u1[i]) < -tolv[i]) || (NUM_WIDTH'(u1[i]) > N_ONE + tolv[i]);
    end
  end

  // stage 8: request flags
  logic        v8;
  clip_flags_t fl8;
  logic [2:0]  use8;

  always_comb begin
    for (int i = 0; i < 3; i++) use8[i] = (e7[i] > thr) || (-e7[i] > thr);
  end

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    fl8.kind      <= kind7;
    fl8.point_rel <= ~|out7;
    fl8.reject    <= |(~use8 & out7);
    fl8.use_axis  <= use8;
  end

  logic signed [T_WIDTH-1:0] lo_d [3];
  logic signed [T_WIDTH-1:0] hi_d [3];

  generate
    for (a = 0; a < 3; a++) begin : g_div
      obsc_div u_div_lo (.clk(clk), .num(nlo7[a]), .den(e7[a]), .quo(lo_d[a]));
      obsc_div u_div_hi (.clk(clk), .num(nhi7[a]), .den(e7[a]), .quo(hi_d[a]));
    end
  endgenerate

  logic [$bits(clip_flags_t):0] sb_d;

  obsc_delay #(.WIDTH($bits(clip_flags_t) + 1), .DEPTH(DIV_LAT - 1)) u_flag_dly (
    .clk  (clk),
    .rst  (rst),
    .din  ({v8, fl8}),
    .dout (sb_d)
  );

  // stage A: order each slab interval
  logic                      va;
  clip_flags_t               fla;
  logic signed [T_WIDTH-1:0] loa [3];
  logic signed [T_WIDTH-1:0] hia [3];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= sb_d[$bits(clip_flags_t)];
    fla <= clip_flags_t'(sb_d[$bits(clip_flags_t)-1:0]);
    for (int i = 0; i < 3; i++) begin
      loa[i] <= (lo_d[i] > hi_d[i]) ? hi_d[i] : lo_d[i];
      hia[i] <= (lo_d[i] > hi_d[i]) ? lo_d[i] : hi_d[i];
    end
  end

  // stage B: intersect the intervals
  logic                      vb;
  clip_flags_t               flb;
  logic signed [T_WIDTH-1:0] t1b, t2b;
  logic signed [T_WIDTH-1:0] t1_next, t2_next;

  always_comb begin
    t1_next = '0;
    t2_next = T_ONE;
    for (int i = 0; i < 3; i++) begin
      if (fla.use_axis[i] && (loa[i] > t1_next)) t1_next = loa[i];
      if (fla.use_axis[i] && (hia[i] < t2_next)) t2_next = hia[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    flb <= fla;
    t1b <= t1_next;
    t2b <= t2_next;
  end

  // stage C: result register
  logic seg_rel;

  assign seg_rel = !($signed({{2{t1b[T_WIDTH-1]}}, t1b}) >
                     ($signed({{2{t2b[T_WIDTH-1]}}, t2b}) -
                      $signed({{(T_WIDTH+2-THR_WIDTH){1'b0}}, segment_tolerance})));

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vb;
    if (flb.kind) begin
      relation <= flb.point_rel;
      t_enter  <= '0;
      t_exit   <= '0;
    end else if (flb.reject) begin
      relation <= 1'b0;
      t_enter  <= '0;
      t_exit   <= T_ONE;
    end else begin
      relation <= seg_rel;
      t_enter  <= t1b;
      t_exit   <= t2b;
    end
  end

endmodule
`default_nettype wire
